// ===== sv/tihc_pkg.sv =====
// Shared types and constants for the turn indicator / hazard controller.
// Used by tihc_step and turn_indicator_hazard_controller; depends on nothing.
package tihc_pkg;

    // Indicator mode codes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_IDLE   = 2'd0;
    localparam mode_t MODE_LEFT   = 2'd1;
    localparam mode_t MODE_RIGHT  = 2'd2;
    localparam mode_t MODE_HAZARD = 2'd3;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    localparam cfg_index_t REG_HOLD_TIME      = 1'b0;
    localparam cfg_index_t REG_BLINK_INTERVAL = 1'b1;

    localparam cfg_data_t HOLD_TIME_RESET      = 16'd1000;
    localparam cfg_data_t BLINK_INTERVAL_RESET = 16'd300;

    // Control state that is not a time stamp
    typedef struct packed {
        mode_t mode;
        logic  flash_phase;
        logic  left_prev;
        logic  right_prev;
        logic  left_lamp;
        logic  right_lamp;
        logic  left_hold_off;
        logic  right_hold_off;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        mode:           MODE_IDLE,
        flash_phase:    1'b0,
        left_prev:      1'b0,
        right_prev:     1'b0,
        left_lamp:      1'b0,
        right_lamp:     1'b0,
        left_hold_off:  1'b0,
        right_hold_off: 1'b0
    };

endpackage

// ===== sv/tihc_step.sv =====
// Next-state logic for one button sample of the indicator controller.
// Depends on tihc_pkg (mode codes, ctrl_t).
module tihc_step #(
    parameter int TIME_BITS = 32
) (
    input  logic                   left,
    input  logic                   right,
    input  logic [TIME_BITS-1:0]   now,
    input  tihc_pkg::cfg_data_t    hold_time,
    input  tihc_pkg::cfg_data_t    blink_interval,
    input  tihc_pkg::ctrl_t        ctrl,
    input  logic [TIME_BITS-1:0]   last_toggle,
    input  logic [TIME_BITS-1:0]   left_start,
    input  logic [TIME_BITS-1:0]   right_start,
    input  logic [TIME_BITS-1:0]   both_start,
    output tihc_pkg::ctrl_t        ctrl_next,
    output logic [TIME_BITS-1:0]   last_toggle_next,
    output logic [TIME_BITS-1:0]   left_start_next,
    output logic [TIME_BITS-1:0]   right_start_next,
    output logic [TIME_BITS-1:0]   both_start_next
);
    import tihc_pkg::*;

    logic [TIME_BITS-1:0] hold_ext;
    logic [TIME_BITS-1:0] blink_ext;

    assign hold_ext  = TIME_BITS'(hold_time);
    assign blink_ext = TIME_BITS'(blink_interval);

    function automatic logic held_past(input logic [TIME_BITS-1:0] t_now,
                                       input logic [TIME_BITS-1:0] t_start,
                                       input logic [TIME_BITS-1:0] limit);
        logic [TIME_BITS-1:0] diff;
        diff = t_now - t_start;
        return diff > limit;
    endfunction

    always_comb
    begin
        logic                 skip;
        logic [TIME_BITS-1:0] since_toggle;

        ctrl_next        = ctrl;
        last_toggle_next = last_toggle;
        left_start_next  = left_start;
        right_start_next = right_start;
        both_start_next  = both_start;
        skip             = 1'b0;
        since_toggle     = '0;

        // Hold off a button that is still pressed after its action
        if (ctrl.left_hold_off)
        begin
            if (left)
                skip = 1'b1;
            else
                ctrl_next.left_hold_off = 1'b0;
        end
        if (!skip && ctrl.right_hold_off)
        begin
            if (right)
                skip = 1'b1;
            else
                ctrl_next.right_hold_off = 1'b0;
        end

        if (!skip)
        begin
            // Record press start times
            if (left && !ctrl.left_prev)
                left_start_next = now;
            if (right && !ctrl.right_prev)
                right_start_next = now;
            if (left && right && (!ctrl.left_prev || !ctrl.right_prev))
                both_start_next = now;

            // Both held: enter hazard
            if (left && right && ctrl_next.mode != MODE_HAZARD
                && held_past(now, both_start_next, hold_ext))
            begin
                ctrl_next.mode        = MODE_HAZARD;
                ctrl_next.flash_phase = 1'b1;
                last_toggle_next      = now;
            end

            // One button held alone in hazard: back to idle
            if (ctrl_next.mode == MODE_HAZARD && (left != right))
            begin
                if ((left && held_past(now, left_start_next, hold_ext))
                    || (right && held_past(now, right_start_next, hold_ext)))
                begin
                    ctrl_next.mode       = MODE_IDLE;
                    ctrl_next.left_lamp  = 1'b0;
                    ctrl_next.right_lamp = 1'b0;
                end
            end

            if (left && !right && ctrl_next.mode != MODE_HAZARD
                && held_past(now, left_start_next, hold_ext))
            begin
                ctrl_next.mode = (ctrl_next.mode == MODE_LEFT) ? MODE_IDLE : MODE_LEFT;
                ctrl_next.left_hold_off = 1'b1;
            end

            if (right && !left && ctrl_next.mode != MODE_HAZARD
                && held_past(now, right_start_next, hold_ext))
            begin
                ctrl_next.mode = (ctrl_next.mode == MODE_RIGHT) ? MODE_IDLE : MODE_RIGHT;
                ctrl_next.right_hold_off = 1'b1;
            end

            // Flash the lamps
            if (ctrl_next.mode != MODE_IDLE)
            begin
                since_toggle = now - last_toggle_next;
                if (since_toggle >= blink_ext)
                begin
                    ctrl_next.flash_phase = ~ctrl_next.flash_phase;
                    last_toggle_next      = now;
                    case (ctrl_next.mode)
                        MODE_LEFT:
                        begin
                            ctrl_next.left_lamp  = ctrl_next.flash_phase;
                            ctrl_next.right_lamp = 1'b0;
                        end
                        MODE_RIGHT:
                        begin
                            ctrl_next.left_lamp  = 1'b0;
                            ctrl_next.right_lamp = ctrl_next.flash_phase;
                        end
                        default:
                        begin
                            ctrl_next.left_lamp  = ctrl_next.flash_phase;
                            ctrl_next.right_lamp = ctrl_next.flash_phase;
                        end
                    endcase
                end
            end
            else
            begin
                ctrl_next.left_lamp  = 1'b0;
                ctrl_next.right_lamp = 1'b0;
            end

            ctrl_next.left_prev  = left;
            ctrl_next.right_prev = right;
        end
    end

endmodule

// ===== sv/turn_indicator_hazard_controller.sv =====
// Top level of the turn indicator / hazard flasher controller.
// Depends on tihc_pkg and tihc_step.
//
// Each input transaction is one button sample with a millisecond time stamp;
// each produces exactly one output transaction with both lamp drives and the
// current mode. The block takes one transaction per clock while in_stall is
// low. A sample is held in the input register; when it advances, the
// combinational update (TIME_BITS-wide subtracts and compares in tihc_step)
// writes the state and the result register together. A result thus passes
// through the input register and then the result register before it is
// offered on the output. The held sample advances whenever the result
// register is free or being taken in the same cycle; while a result is
// stalled, one more sample is taken into the input register before in_stall
// rises. Time differences wrap at TIME_BITS bits. Write the hold time and
// blink interval registers only while no transaction is in flight.
module turn_indicator_hazard_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  left_pressed,
    input  logic                  right_pressed,
    input  logic [31:0]           time_stamp_ms,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  left_lamp,
    output logic                  right_lamp,
    output tihc_pkg::mode_t       mode,
    // configuration
    input  logic                  cfg_we,
    input  tihc_pkg::cfg_index_t  cfg_index,
    input  tihc_pkg::cfg_data_t   cfg_data
);
    import tihc_pkg::*;

    // configuration registers
    cfg_data_t hold_time_reg;
    cfg_data_t blink_interval_reg;

    // input register
    logic                 in_valid_reg;
    logic                 left_reg;
    logic                 right_reg;
    logic [TIME_BITS-1:0] now_reg;

    // block state
    ctrl_t                ctrl_reg;
    ctrl_t                ctrl_next;
    logic [TIME_BITS-1:0] last_toggle_reg;
    logic [TIME_BITS-1:0] left_start_reg;
    logic [TIME_BITS-1:0] right_start_reg;
    logic [TIME_BITS-1:0] both_start_reg;
    logic [TIME_BITS-1:0] last_toggle_next;
    logic [TIME_BITS-1:0] left_start_next;
    logic [TIME_BITS-1:0] right_start_next;
    logic [TIME_BITS-1:0] both_start_next;

    // result register
    logic                 out_valid_reg;
    logic                 left_lamp_reg;
    logic                 right_lamp_reg;
    mode_t                mode_reg;

    logic                 advance;
    logic                 in_take;
    logic [TIME_BITS+31:0] stamp_wide;

    // Fit the 32-bit stamp to TIME_BITS: truncate or zero-extend
    assign stamp_wide = {{TIME_BITS{1'b0}}, time_stamp_ms};

    // Advance the held sample when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg      <= HOLD_TIME_RESET;
            blink_interval_reg <= BLINK_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOLD_TIME:      hold_time_reg      <= cfg_data;
                REG_BLINK_INTERVAL: blink_interval_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Input register: hold the sample until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_reg  <= left_pressed;
            right_reg <= right_pressed;
            now_reg   <= stamp_wide[TIME_BITS-1:0];
        end
    end

    tihc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .left             (left_reg),
        .right            (right_reg),
        .now              (now_reg),
        .hold_time        (hold_time_reg),
        .blink_interval   (blink_interval_reg),
        .ctrl             (ctrl_reg),
        .last_toggle      (last_toggle_reg),
        .left_start       (left_start_reg),
        .right_start      (right_start_reg),
        .both_start       (both_start_reg),
        .ctrl_next        (ctrl_next),
        .last_toggle_next (last_toggle_next),
        .left_start_next  (left_start_next),
        .right_start_next (right_start_next),
        .both_start_next  (both_start_next)
    );

    // State update: commit only when the sample advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg        <= CTRL_RESET;
            last_toggle_reg <= '0;
            left_start_reg  <= '0;
            right_start_reg <= '0;
            both_start_reg  <= '0;
        end
        else if (advance)
        begin
            ctrl_reg        <= ctrl_next;
            last_toggle_reg <= last_toggle_next;
            left_start_reg  <= left_start_next;
            right_start_reg <= right_start_next;
            both_start_reg  <= both_start_next;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_lamp_reg  <= ctrl_next.left_lamp;
            right_lamp_reg <= ctrl_next.right_lamp;
            mode_reg       <= ctrl_next.mode;
        end
    end

    assign out_valid  = out_valid_reg;
    assign left_lamp  = left_lamp_reg;
    assign right_lamp = right_lamp_reg;
    assign mode       = mode_reg;

endmodule
